FILE: sv/prqm_pkg.sv
`default_nettype none

package prqm_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W   = 2;
    localparam int TASK_IN_W = 6;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LVL,
        S_RD_HT,
        S_RD_LINK,
        S_COMMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic rd_lvl;
        logic rd_ht;
        logic rd_link;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/prqm_ctrl.sv
`default_nettype none

module prqm_ctrl
    import prqm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_RD_LVL;
            S_RD_LVL:  n_state = S_RD_HT;
            S_RD_HT:   n_state = S_RD_LINK;
            S_RD_LINK: n_state = S_COMMIT;
            S_COMMIT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Drive commands
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_RD_LVL:  o_cmd.rd_lvl  = 1'b1;
            S_RD_HT:   o_cmd.rd_ht   = 1'b1;
            S_RD_LINK: o_cmd.rd_link = 1'b1;
            S_COMMIT:  o_cmd.commit  = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/prqm_dp.sv
`default_nettype none

module prqm_dp
    import prqm_pkg::*;
#(
    parameter int NUM_TASKS  = 64,
    parameter int NUM_LEVELS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [TASK_IN_W-1:0] i_task_id,
    input  wire logic [PRIO_W-1:0]    i_priority_req,
    output logic                      o_strobe,
    output logic [STATUS_W-1:0]       o_status,
    output logic [TASK_IN_W-1:0]      o_task_out
);

    localparam int TASK_W = $clog2(NUM_TASKS);
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    // Link and level memories; entries are written before any read that matters
    logic [TASK_W-1:0] next_mem  [NUM_TASKS];
    logic [TASK_W-1:0] prev_mem  [NUM_TASKS];
    logic [LVL_W-1:0]  level_mem [NUM_TASKS];
    logic [TASK_W-1:0] head_mem  [NUM_LEVELS];
    logic [TASK_W-1:0] tail_mem  [NUM_LEVELS];

    // Per-task queued flags and per-level nonempty flags
    logic [NUM_TASKS-1:0]  r_queued;
    logic [NUM_LEVELS-1:0] r_nonempty;

    // Latched request word
    logic [FUNC_W-1:0]    r_func;
    logic [TASK_IN_W-1:0] r_task_in;
    logic [PRIO_W-1:0]    r_prio;

    // Registered memory reads
    logic [LVL_W-1:0]  r_lvl_q;
    logic              r_queued_q;
    logic [TASK_W-1:0] r_head_q;
    logic [TASK_W-1:0] r_tail_q;
    logic              r_ne_q;
    logic [TASK_W-1:0] r_next_q;
    logic [TASK_W-1:0] r_prev_q;

    // Result registers
    logic                 r_strobe;
    logic [STATUS_W-1:0]  r_status;
    logic [TASK_IN_W-1:0] r_task_out;

    // Decoded request
    logic              task_ok;
    logic              prio_ok;
    logic [TASK_W-1:0] tidx;
    logic [LVL_W-1:0]  prio_idx;
    logic              queued;
    logic [LVL_W-1:0]  ht_addr;
    logic [TASK_W-1:0] link_addr;

    // Commit-time updates
    logic [STATUS_W-1:0]  n_status;
    logic [TASK_IN_W-1:0] n_task_out;
    logic                 next_we;
    logic [TASK_W-1:0]    next_wa;
    logic [TASK_W-1:0]    next_wd;
    logic                 prev_we;
    logic [TASK_W-1:0]    prev_wa;
    logic [TASK_W-1:0]    prev_wd;
    logic                 head_we;
    logic [TASK_W-1:0]    head_wd;
    logic                 tail_we;
    logic [TASK_W-1:0]    tail_wd;
    logic                 lvl_we;
    logic                 ne_set;
    logic                 ne_clr;
    logic                 q_set;
    logic                 q_clr;
    logic [TASK_W-1:0]    q_addr;
    logic [TASK_W-1:0]    ul_t;
    logic                 is_head;
    logic                 is_tail;
    logic                 do_unlink;

    // Decode request fields
    assign task_ok  = (32'(r_task_in) < 32'(NUM_TASKS));
    assign prio_ok  = (32'(r_prio) < 32'(NUM_LEVELS));
    assign tidx     = task_ok ? TASK_W'(r_task_in) : '0;
    assign prio_idx = prio_ok ? LVL_W'(r_prio) : '0;
    assign queued   = task_ok && r_queued_q;
    assign ht_addr  = (r_func == FUNC_DEL) ? r_lvl_q : prio_idx;
    assign link_addr = (r_func == FUNC_GET) ? r_head_q : tidx;

    // Latch request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_task_in <= i_task_id;
            r_prio    <= i_priority_req;
        end
    end

    // Read level and queued flag, then head and tail, then links
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_lvl) begin
            r_lvl_q    <= level_mem[tidx];
            r_queued_q <= r_queued[tidx];
        end
        if (i_cmd.rd_ht) begin
            r_head_q <= head_mem[ht_addr];
            r_tail_q <= tail_mem[ht_addr];
            r_ne_q   <= r_nonempty[ht_addr];
        end
        if (i_cmd.rd_link) begin
            r_next_q <= next_mem[link_addr];
            r_prev_q <= prev_mem[link_addr];
        end
    end

    // Work out status and list updates
    always_comb begin
        n_status   = ST_OK;
        n_task_out = '0;
        next_we    = 1'b0;
        next_wa    = r_prev_q;
        next_wd    = r_next_q;
        prev_we    = 1'b0;
        prev_wa    = r_next_q;
        prev_wd    = r_prev_q;
        head_we    = 1'b0;
        head_wd    = r_next_q;
        tail_we    = 1'b0;
        tail_wd    = r_prev_q;
        lvl_we     = 1'b0;
        ne_set     = 1'b0;
        ne_clr     = 1'b0;
        q_set      = 1'b0;
        q_clr      = 1'b0;
        q_addr     = tidx;
        do_unlink  = 1'b0;
        ul_t       = (r_func == FUNC_GET) ? r_head_q : tidx;
        is_head    = (r_head_q == ul_t);
        is_tail    = (r_tail_q == ul_t);

        unique case (r_func)
            FUNC_PUT: begin
                if (!prio_ok) begin
                    n_status = ST_BAD_PRIO;
                end else if (!task_ok) begin
                    n_status = ST_NOT_QUEUED;
                end else if (queued) begin
                    n_status = ST_ALREADY;
                end else begin
                    // Append at tail
                    if (r_ne_q) begin
                        prev_we = 1'b1;
                        prev_wa = tidx;
                        prev_wd = r_tail_q;
                        next_we = 1'b1;
                        next_wa = r_tail_q;
                        next_wd = tidx;
                    end else begin
                        head_we = 1'b1;
                        head_wd = tidx;
                        ne_set  = 1'b1;
                    end
                    tail_we = 1'b1;
                    tail_wd = tidx;
                    q_set   = 1'b1;
                    lvl_we  = 1'b1;
                end
            end
            FUNC_GET: begin
                if (!prio_ok) begin
                    n_status = ST_BAD_PRIO;
                end else if (!r_ne_q) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_unlink  = 1'b1;
                    n_task_out = TASK_IN_W'(r_head_q);
                end
            end
            FUNC_DEL: begin
                if (!queued) begin
                    n_status = ST_NOT_QUEUED;
                end else begin
                    do_unlink = 1'b1;
                end
            end
            FUNC_NOP: n_status = ST_OK;
            default:  n_status = ST_OK;
        endcase

        // Unlink task from its list
        if (do_unlink) begin
            q_clr  = 1'b1;
            q_addr = ul_t;
            if (is_head && is_tail) begin
                ne_clr = 1'b1;
            end else begin
                if (is_head) begin
                    head_we = 1'b1;
                end else begin
                    next_we = 1'b1;
                end
                if (is_tail) begin
                    tail_we = 1'b1;
                end else begin
                    prev_we = 1'b1;
                end
            end
        end
    end

    // Write memories on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (next_we) next_mem[next_wa] <= next_wd;
            if (prev_we) prev_mem[prev_wa] <= prev_wd;
            if (head_we) head_mem[ht_addr] <= head_wd;
            if (tail_we) tail_mem[ht_addr] <= tail_wd;
            if (lvl_we)  level_mem[tidx]   <= prio_idx;
        end
    end

    // Update flags on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued   <= '0;
            r_nonempty <= '0;
        end else if (i_cmd.commit) begin
            if (q_set) r_queued[q_addr] <= 1'b1;
            if (q_clr) r_queued[q_addr] <= 1'b0;
            if (ne_set) r_nonempty[ht_addr] <= 1'b1;
            if (ne_clr) r_nonempty[ht_addr] <= 1'b0;
        end
    end

    // Register the strobe and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_task_out <= n_task_out;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_task_out = r_task_out;

endmodule

`default_nettype wire

FILE: sv/priority_ready_queue_manager_core.sv
`default_nettype none

// Per-priority FIFO ready queues of task ids, one doubly linked list per level.
// A word is accepted when start is high and busy is low; its result appears on
// o_status/o_task_out for exactly one cycle with o_strobe high, and the receiver
// cannot stall it. A new word cannot be accepted while busy is high; the result
// strobes after the controller steps through its read and commit states, and busy
// drops in that same cycle so the next word can be accepted alongside the strobe.
// The sequence comes from three dependent registered memory reads (task level,
// then list head and tail, then the task's links) followed by a commit step. No
// clearing pass is needed after reset.
module priority_ready_queue_manager_core
    import prqm_pkg::*;
#(
    parameter int NUM_TASKS  = 64,
    parameter int NUM_LEVELS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [TASK_IN_W-1:0] i_task_id,
    input  wire logic [PRIO_W-1:0]    i_priority_req,
    output logic                      o_strobe,
    output logic [STATUS_W-1:0]       o_status,
    output logic [TASK_IN_W-1:0]      o_task_out
);

    t_cmd cmd;

    // Sequence the operation
    prqm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Hold the lists and compute results
    prqm_dp #(
        .NUM_TASKS  (NUM_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_task_out     (o_task_out)
    );

endmodule

`default_nettype wire

FILE: sim/priority_ready_queue_manager_core_test.sv
`default_nettype none

module priority_ready_queue_manager_core_test;
    import prqm_pkg::*;

    localparam int TASKS      = 64;
    localparam int LEVELS     = 8;
    localparam int RAND_WORDS = 450;
    localparam int CALM_WORDS = 100;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [6:0] LINK_NONE = 7'h40;

    // One expected result, with the word that caused it for reporting
    typedef struct {
        logic [FUNC_W-1:0]    func;
        logic [TASK_IN_W-1:0] task_id;
        logic [PRIO_W-1:0]    prio;
        logic [STATUS_W-1:0]  status;
        logic [TASK_IN_W-1:0] task_out;
    } t_ready_result;

    // Mirror of the ready queues plus the store of results still owed
    class ready_queue_scoreboard;
        logic [6:0] head [LEVELS];
        logic [6:0] tail [LEVELS];
        logic [6:0] nxt [TASKS];
        logic [6:0] prv [TASKS];
        bit         queued [TASKS];
        logic [2:0] level [TASKS];
        t_ready_result owed [$];
        int mismatches;

        function new();
            for (int i = 0; i < LEVELS; i++) begin
                head[i] = LINK_NONE;
                tail[i] = LINK_NONE;
            end
            for (int i = 0; i < TASKS; i++) begin
                nxt[i] = LINK_NONE;
                prv[i] = LINK_NONE;
                queued[i] = 1'b0;
                level[i] = 3'd0;
            end
            mismatches = 0;
        endfunction

        // Drop task t from the list of level lvl and clear its links
        function void unlink(logic [5:0] t, logic [2:0] lvl);
            logic [6:0] p;
            logic [6:0] n;
            p = prv[t];
            n = nxt[t];
            if (!p[6]) nxt[p[5:0]] = n;
            else head[lvl] = n;
            if (!n[6]) prv[n[5:0]] = p;
            else tail[lvl] = p;
            nxt[t] = LINK_NONE;
            prv[t] = LINK_NONE;
            queued[t] = 1'b0;
        endfunction

        // Apply an accepted word to the mirror and queue its result
        function void note_word(logic [FUNC_W-1:0] f, logic [TASK_IN_W-1:0] t,
                                logic [PRIO_W-1:0] p);
            t_ready_result r;
            logic [6:0] tl;
            logic [6:0] h;
            r.func = f;
            r.task_id = t;
            r.prio = p;
            r.status = ST_OK;
            r.task_out = '0;
            case (f)
                FUNC_PUT: begin
                    if (p >= LEVELS) begin
                        r.status = ST_BAD_PRIO;
                    end else if (queued[t]) begin
                        r.status = ST_ALREADY;
                    end else begin
                        tl = tail[p[2:0]];
                        nxt[t] = LINK_NONE;
                        prv[t] = tl;
                        if (!tl[6]) nxt[tl[5:0]] = {1'b0, t};
                        else head[p[2:0]] = {1'b0, t};
                        tail[p[2:0]] = {1'b0, t};
                        queued[t] = 1'b1;
                        level[t] = p[2:0];
                    end
                end
                FUNC_GET: begin
                    if (p >= LEVELS) begin
                        r.status = ST_BAD_PRIO;
                    end else begin
                        h = head[p[2:0]];
                        if (h[6]) begin
                            r.status = ST_EMPTY;
                        end else begin
                            unlink(h[5:0], p[2:0]);
                            r.task_out = h[5:0];
                        end
                    end
                end
                FUNC_DEL: begin
                    if (!queued[t]) r.status = ST_NOT_QUEUED;
                    else unlink(t, level[t]);
                end
                default: ;
            endcase
            owed.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        // Compare a strobed result with the oldest one owed
        function void check_result(logic [STATUS_W-1:0] st, logic [TASK_IN_W-1:0] tk);
            t_ready_result r;
            if (owed.size() == 0) begin
                flag($sformatf("result status %0d task %0d with no word waiting", st, tk));
            end else begin
                r = owed.pop_front();
                if (st !== r.status || tk !== r.task_out)
                    flag($sformatf(
                        "func %0d task %0d prio %0d: expected status %0d task %0d, got status %0d task %0d",
                        r.func, r.task_id, r.prio, r.status, r.task_out, st, tk));
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    word_func = FUNC_NOP;
    logic [TASK_IN_W-1:0] word_task = '0;
    logic [PRIO_W-1:0]    word_prio = '0;
    logic                 o_strobe;
    logic [STATUS_W-1:0]  o_status;
    logic [TASK_IN_W-1:0] o_task_out;
    int                   cycle_count = 0;

    ready_queue_scoreboard sb = new();

    priority_ready_queue_manager_core #(
        .NUM_TASKS(TASKS),
        .NUM_LEVELS(LEVELS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(word_func),
        .i_task_id(word_task),
        .i_priority_req(word_prio),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_task_out(o_task_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Count cycles for the watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Note accepted words and check strobed results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_word(word_func, word_task, word_prio);
            if (o_strobe) sb.check_result(o_status, o_task_out);
        end
    end

    // End a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Present a word and hold it until accepted
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [TASK_IN_W-1:0] t,
                             input logic [PRIO_W-1:0] p);
        start <= 1'b1;
        word_func <= f;
        word_task <= t;
        word_prio <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Idle with start low and noise on the fields
    task automatic idle_for(input int n);
        repeat (n) begin
            start <= 1'b0;
            word_func <= FUNC_W'($urandom);
            word_task <= TASK_IN_W'($urandom);
            word_prio <= PRIO_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Pick a level, leaning on levels 0 to 2 so that lists grow long
    function automatic logic [PRIO_W-1:0] pick_level();
        if ($urandom_range(0, 9) < 6) return PRIO_W'($urandom_range(0, 2));
        return PRIO_W'($urandom_range(0, LEVELS - 1));
    endfunction

    // Prefer a queued task; fall back to any task
    function automatic logic [TASK_IN_W-1:0] pick_queued();
        int base;
        base = $urandom_range(0, TASKS - 1);
        for (int i = 0; i < TASKS; i++)
            if (sb.queued[(base + i) % TASKS]) return TASK_IN_W'((base + i) % TASKS);
        return TASK_IN_W'(base);
    endfunction

    // Send one random word, mostly well formed
    task automatic send_random();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            send_word(FUNC_PUT, TASK_IN_W'($urandom_range(0, TASKS - 1)), pick_level());
        else if (roll < 72)
            send_word(FUNC_GET, TASK_IN_W'($urandom), pick_level());
        else if (roll < 90)
            send_word(FUNC_DEL, pick_queued(), PRIO_W'($urandom));
        else if (roll < 95)
            send_word(roll[0] ? FUNC_GET : FUNC_PUT, TASK_IN_W'($urandom),
                      PRIO_W'($urandom_range(LEVELS, 255)));
        else if (roll < 98)
            send_word(FUNC_NOP, TASK_IN_W'($urandom), PRIO_W'($urandom));
        else
            send_word(FUNC_DEL, TASK_IN_W'($urandom), PRIO_W'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queues, bad levels, unqueued delete, unused code
        send_word(FUNC_GET, 6'd0, 8'd0);
        send_word(FUNC_GET, 6'd63, 8'd7);
        send_word(FUNC_PUT, 6'd0, 8'd8);
        send_word(FUNC_PUT, 6'd63, 8'd255);
        send_word(FUNC_GET, 6'd0, 8'd255);
        send_word(FUNC_DEL, 6'd5, 8'd0);
        send_word(FUNC_NOP, 6'd63, 8'd255);
        // Put twice, extremes of task and level
        send_word(FUNC_PUT, 6'd0, 8'd0);
        send_word(FUNC_PUT, 6'd0, 8'd3);
        send_word(FUNC_PUT, 6'd63, 8'd7);
        // Delete from middle, head and tail of one list
        send_word(FUNC_PUT, 6'd1, 8'd0);
        send_word(FUNC_PUT, 6'd2, 8'd0);
        send_word(FUNC_PUT, 6'd3, 8'd0);
        send_word(FUNC_DEL, 6'd2, 8'd0);
        send_word(FUNC_DEL, 6'd0, 8'd0);
        send_word(FUNC_DEL, 6'd3, 8'd0);
        send_word(FUNC_GET, 6'd0, 8'd0);
        send_word(FUNC_GET, 6'd0, 8'd0);
        send_word(FUNC_GET, 6'd0, 8'd7);
        // Delete a lone entry, then check FIFO order after reuse
        send_word(FUNC_PUT, 6'd10, 8'd5);
        send_word(FUNC_DEL, 6'd10, 8'd255);
        send_word(FUNC_PUT, 6'd10, 8'd5);
        send_word(FUNC_PUT, 6'd11, 8'd5);
        send_word(FUNC_GET, 6'd0, 8'd5);
        send_word(FUNC_GET, 6'd0, 8'd5);

        // Random words; idle bursts in alternating stretches, none at the end
        for (int i = 0; i < RAND_WORDS; i++) begin
            send_random();
            if (i < RAND_WORDS - CALM_WORDS && (i / 40) % 2 == 0 &&
                $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 13));
        end

        // Drain outstanding results, then allow the pipeline to settle
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
